// ----- rtl/core/i2csr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2csr_pkg
// Shared types and constants of the I2C sensor register target: event codes,
// generator constants, and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package i2csr_pkg;

    localparam int FILE_BYTES = 8;
    localparam int FILE_AW    = $clog2(FILE_BYTES);

    localparam logic [6:0]  RESET_ADDRESS = 7'h68;
    localparam logic [31:0] LCG_MUL       = 32'd1664525;
    localparam logic [31:0] LCG_ADD       = 32'd1013904223;
    localparam logic [31:0] LCG_SEED      = 32'hDEADBEEF;

    // remainder moduli: 2*16384+1 for X and Y, 2*1000+1 for the offset
    localparam logic [15:0] XY_MODULUS  = 16'd32769;
    localparam logic [16:0] XY_MODULUS2 = 17'd65538;
    localparam logic [15:0] Z_MODULUS   = 16'd2001;
    localparam logic [15:0] Z_MODULUS2  = 16'd4002;
    // 2^11 mod 2001, weight of the bits above the low eleven in a fold
    localparam logic [5:0]  Z_FOLD      = 6'd47;
    localparam logic [15:0] XY_RANGE    = 16'd16384;
    // 16384 base minus the 1000 range
    localparam logic [15:0] Z_OFFSET   = 16'd15384;
    localparam logic [7:0]  PAST_END   = 8'hFF;

    // fold cycles per draw; four folds bring any word below three moduli
    localparam int          FOLD_STEPS = 4;
    localparam logic [1:0]  LAST_FOLD  = 2'(FOLD_STEPS - 1);
    localparam logic [1:0]  LAST_DRAW  = 2'd2;

    typedef enum logic [1:0] {
        ACT_CONNECT    = 2'd0,
        ACT_READ       = 2'd1,
        ACT_WRITE      = 2'd2,
        ACT_DISCONNECT = 2'd3
    } action_t;

    typedef struct packed {
        logic       accept;
        logic       gen_step;
        logic       mod_step;
        logic       store;
        logic [1:0] draw;
    } dp_cmd_t;

    typedef struct packed {
        logic refresh;
    } dp_status_t;

endpackage

// ----- rtl/core/i2c_sensor_register_target.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_sensor_register_target
// I2C target with an eight-byte read-only sensor register file and an
// auto-incrementing register pointer, driven by decoded bus events.
// ----------------------------------------------------------------------------
// Each event item gives one result item, registered and ready the cycle after
// the item is taken; a new item is taken while the previous result still
// waits, as long as the result register frees in the same cycle. A connect
// for reading at the device address refreshes the file and keeps the block
// busy for three generator draws, each one multiply step, four modular fold
// steps and one store step. All other events leave the block idle. The
// device address is written through the cfg port and resets to 0x68.
module i2c_sensor_register_target (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data,       // device_address
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // bus_address[6:0], is_read[7],
                                        // write_byte[15:8], temp_code[29:16]
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // ack[0], read_byte[8:1]
);

    i2csr_pkg::dp_cmd_t    cmd;
    i2csr_pkg::dp_status_t status;
    logic                  ack;
    logic [7:0]            read_byte;

    assign cfg_ready = 1'b1;

    i2csr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    i2csr_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .action      (s_axis_tuser),
        .bus_address (s_axis_tdata[6:0]),
        .is_read     (s_axis_tdata[7]),
        .write_byte  (s_axis_tdata[15:8]),
        .temp_code   (s_axis_tdata[29:16]),
        .cfg_we      (cfg_valid),
        .cfg_address (cfg_data),
        .ack         (ack),
        .read_byte   (read_byte)
    );

    assign m_axis_tdata = {7'd0, read_byte, ack};

endmodule

// ----- rtl/core/i2csr_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2csr_datapath
// Register file, pointer, address register, generator and remainder unit,
// and the result register of the I2C sensor register target.
// ----------------------------------------------------------------------------
module i2csr_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  i2csr_pkg::dp_cmd_t    cmd,
    output i2csr_pkg::dp_status_t status,
    input  logic [1:0]            action,
    input  logic [6:0]            bus_address,
    input  logic                  is_read,
    input  logic [7:0]            write_byte,
    input  logic [13:0]           temp_code,
    input  logic                  cfg_we,
    input  logic [6:0]            cfg_address,
    output logic                  ack,
    output logic [7:0]            read_byte
);

    logic [7:0]  file_reg [i2csr_pkg::FILE_BYTES];
    logic [7:0]  ptr_reg;
    logic [7:0]  ptr_next;
    logic        pv_reg;
    logic        pv_next;
    logic [6:0]  dev_addr_reg;
    logic [31:0] gen_reg;
    logic [31:0] gen_next;
    logic [31:0] mod_reg;
    logic [31:0] mod_next;
    logic        ack_reg;
    logic        ack_next;
    logic [7:0]  byte_reg;
    logic [7:0]  byte_next;
    logic        addr_match;
    logic [16:0] xy_sum;
    logic [16:0] xy_rem;
    logic [26:0] z_prod;
    logic [31:0] z_fold;
    logic [15:0] z_low;
    logic [15:0] rem_value;
    logic [15:0] draw_value;
    logic [2:0]  store_idx;
    logic [31:0] gen_product;

    assign addr_match = (bus_address == dev_addr_reg);
    assign status.refresh = (i2csr_pkg::action_t'(action) == i2csr_pkg::ACT_CONNECT)
                            && addr_match && is_read;

    // effect of one item on pointer, flag and result
    always_comb
    begin
        ptr_next  = ptr_reg;
        pv_next   = pv_reg;
        ack_next  = 1'b0;
        byte_next = 8'd0;
        case (i2csr_pkg::action_t'(action))
            i2csr_pkg::ACT_CONNECT:
            begin
                if (addr_match)
                begin
                    ack_next = 1'b1;
                    pv_next  = 1'b0;
                end
            end
            i2csr_pkg::ACT_READ:
            begin
                if (ptr_reg[7:i2csr_pkg::FILE_AW] == '0)
                begin
                    byte_next = file_reg[ptr_reg[i2csr_pkg::FILE_AW-1:0]];
                    ptr_next  = ptr_reg + 8'd1;
                end
                else
                begin
                    byte_next = i2csr_pkg::PAST_END;
                end
            end
            i2csr_pkg::ACT_WRITE:
            begin
                if (!pv_reg)
                begin
                    if (write_byte[7:i2csr_pkg::FILE_AW] == '0)
                    begin
                        ptr_next = write_byte;
                        pv_next  = 1'b1;
                        ack_next = 1'b1;
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + 8'd1;
                    ack_next = 1'b1;
                end
            end
            i2csr_pkg::ACT_DISCONNECT:
            begin
                pv_next = 1'b0;
            end
            default:
            begin
                pv_next = pv_reg;
            end
        endcase
    end

    // 2^15 = -1 mod 32769, so the word folds to top + low - middle
    assign xy_sum = 17'(mod_reg[31:30]) + 17'(mod_reg[14:0])
                    + (17'(i2csr_pkg::XY_MODULUS) - 17'(mod_reg[29:15]));

    always_comb
    begin
        if (xy_sum >= i2csr_pkg::XY_MODULUS2)
        begin
            xy_rem = xy_sum - i2csr_pkg::XY_MODULUS2;
        end
        else if (xy_sum >= {1'b0, i2csr_pkg::XY_MODULUS})
        begin
            xy_rem = xy_sum - {1'b0, i2csr_pkg::XY_MODULUS};
        end
        else
        begin
            xy_rem = xy_sum;
        end
    end

    // 2^11 = 47 mod 2001, so the word folds to high * 47 + low
    assign z_prod   = {6'd0, mod_reg[31:11]} * {21'd0, i2csr_pkg::Z_FOLD};
    assign z_fold   = {5'd0, z_prod} + {21'd0, mod_reg[10:0]};
    assign mod_next = (cmd.draw == i2csr_pkg::LAST_DRAW) ? z_fold : {15'd0, xy_rem};

    // after the folds the offset word is below 5056, at most two moduli over
    assign z_low = {3'd0, mod_reg[12:0]};

    always_comb
    begin
        if (cmd.draw != i2csr_pkg::LAST_DRAW)
        begin
            rem_value = mod_reg[15:0];
        end
        else if (z_low >= i2csr_pkg::Z_MODULUS2)
        begin
            rem_value = z_low - i2csr_pkg::Z_MODULUS2;
        end
        else if (z_low >= i2csr_pkg::Z_MODULUS)
        begin
            rem_value = z_low - i2csr_pkg::Z_MODULUS;
        end
        else
        begin
            rem_value = z_low;
        end
    end

    assign draw_value  = (cmd.draw == i2csr_pkg::LAST_DRAW) ? rem_value + i2csr_pkg::Z_OFFSET
                                                           : rem_value - i2csr_pkg::XY_RANGE;
    assign store_idx   = 3'({cmd.draw, 1'b0}) + 3'd2;
    assign gen_product = gen_reg * i2csr_pkg::LCG_MUL;
    assign gen_next    = gen_product + i2csr_pkg::LCG_ADD;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < i2csr_pkg::FILE_BYTES; i++)
            begin
                file_reg[i] <= 8'd0;
            end
            ptr_reg      <= 8'd0;
            pv_reg       <= 1'b0;
            dev_addr_reg <= i2csr_pkg::RESET_ADDRESS;
            gen_reg      <= i2csr_pkg::LCG_SEED;
            mod_reg      <= 32'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                dev_addr_reg <= cfg_address;
            end
            if (cmd.accept)
            begin
                ptr_reg <= ptr_next;
                pv_reg  <= pv_next;
                if (status.refresh)
                begin
                    file_reg[0] <= temp_code[7:0];
                    file_reg[1] <= {2'b00, temp_code[13:8]};
                end
            end
            if (cmd.gen_step)
            begin
                gen_reg <= gen_next;
                mod_reg <= gen_next;
            end
            if (cmd.mod_step)
            begin
                mod_reg <= mod_next;
            end
            if (cmd.store)
            begin
                file_reg[store_idx]        <= draw_value[7:0];
                file_reg[store_idx + 3'd1] <= draw_value[15:8];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ack_reg  <= ack_next;
            byte_reg <= byte_next;
        end
    end

    assign ack       = ack_reg;
    assign read_byte = byte_reg;

endmodule

// ----- rtl/core/i2csr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2csr_ctrl
// Controller of the I2C sensor register target: item handshake, result
// valid, and the sequence of the three generator draws of a refresh.
// ----------------------------------------------------------------------------
module i2csr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  i2csr_pkg::dp_status_t status,
    output i2csr_pkg::dp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_MOD,
        ST_STORE
    } state_t;

    state_t     state_reg;
    logic       out_valid_reg;
    logic [1:0] draw_reg;
    logic [1:0] fold_reg;
    logic       accept;

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.accept   = accept;
        cmd.gen_step = (state_reg == ST_MUL);
        cmd.mod_step = (state_reg == ST_MOD);
        cmd.store    = (state_reg == ST_STORE);
        cmd.draw     = draw_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            draw_reg      <= 2'd0;
            fold_reg      <= 2'd0;
        end
        else
        begin
            // result register: loaded on accept, freed when taken
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && status.refresh)
                    begin
                        draw_reg  <= 2'd0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    fold_reg  <= 2'd0;
                    state_reg <= ST_MOD;
                end
                ST_MOD:
                begin
                    fold_reg <= fold_reg + 2'd1;
                    if (fold_reg == i2csr_pkg::LAST_FOLD)
                    begin
                        state_reg <= ST_STORE;
                    end
                end
                ST_STORE:
                begin
                    if (draw_reg == i2csr_pkg::LAST_DRAW)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        draw_reg  <= draw_reg + 2'd1;
                        state_reg <= ST_MUL;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
